>>> src/rtfpt_pkg.sv
// ----------------------------------------------------------------------------
// RTF to plain text package
// Shared types, character constants and keyword tables of the filter.
// ----------------------------------------------------------------------------
package rtfpt_pkg;

   // Character codes used by the parser.
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_TILDE     = 8'h7E;
   localparam logic [7:0] CH_QUESTION  = 8'h3F;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_UNDER     = 8'h5F;
   localparam logic [7:0] CH_COLON     = 8'h3A;

   // Header and keyword lengths.
   localparam logic [2:0] HEADER_LEN = 3'd5;
   localparam logic [3:0] TAB_LEN    = 4'd3;
   localparam logic [3:0] FONT_LEN   = 4'd7;
   localparam logic [3:0] COLOR_LEN  = 4'd8;
   localparam logic [3:0] WORD_SAT   = 4'd8;
   localparam logic [3:0] HEX_DIGITS = 4'd2;

   // Parser modes.
   typedef enum logic [3:0] {
      MODE_TEXT   = 4'd0,
      MODE_ESC    = 4'd1,
      MODE_ALPHA  = 4'd2,
      MODE_DIGITS = 4'd3,
      MODE_HEX    = 4'd4,
      MODE_AFTER  = 4'd5,
      MODE_SKIP   = 4'd6
   } rtfpt_mode_type;

   // One result as it leaves the parser.
   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       doc_end;
      logic       header_error;
   } rtfpt_result_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_xdigit(input logic [7:0] c);
      return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // Header "{\rtf" by position.
   function automatic logic [7:0] header_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = CH_LBRACE;
         3'd1:    ch = CH_BACKSLASH;
         3'd2:    ch = 8'h72;
         3'd3:    ch = 8'h74;
         3'd4:    ch = 8'h66;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Keyword "tab" by position.
   function automatic logic [7:0] tab_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h74;
         4'd1:    ch = 8'h61;
         4'd2:    ch = 8'h62;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Keyword "fonttbl" by position.
   function automatic logic [7:0] font_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h66;
         4'd1:    ch = 8'h6F;
         4'd2:    ch = 8'h6E;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h74;
         4'd5:    ch = 8'h62;
         4'd6:    ch = 8'h6C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Keyword "colortbl" by position.
   function automatic logic [7:0] color_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h63;
         4'd1:    ch = 8'h6F;
         4'd2:    ch = 8'h6C;
         4'd3:    ch = 8'h6F;
         4'd4:    ch = 8'h72;
         4'd5:    ch = 8'h74;
         4'd6:    ch = 8'h62;
         4'd7:    ch = 8'h6C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> src/rtfpt_parser.sv
// ----------------------------------------------------------------------------
// RTF parser core
// Holds the parse state and turns one document byte into one result.
// ----------------------------------------------------------------------------
module rtfpt_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [7:0]                  in_byte,
   input  logic                        last_byte,
   output rtfpt_pkg::rtfpt_result_type result
);
   import rtfpt_pkg::*;

   rtfpt_mode_type mode_ff, mode_in, parse_mode;
   logic [2:0]     header_pos_ff, header_pos_in;
   logic           header_bad_ff, header_bad_in;
   logic [3:0]     word_len_ff, word_len_in, parse_len;
   logic [2:0]     word_match_ff, word_match_in, parse_match;

   logic [3:0] fl_len, fl_len_next;
   logic [2:0] fl_match, fl_match_next;
   logic       tab_hit, font_hit, color_hit;
   logic       tab_done, font_done, color_done;
   logic       reproc;
   logic       text_emit, header_check;
   logic       emit;
   logic [7:0] emit_byte;

   // Header check on the first five bytes.
   always_comb begin
      header_check  = !header_bad_ff && (header_pos_ff < HEADER_LEN);
      header_bad_in = header_bad_ff;
      header_pos_in = header_pos_ff;
      if (header_check) begin
         if (in_byte != header_char(header_pos_ff)) begin
            header_bad_in = 1'b1;
         end else begin
            header_pos_in = header_pos_ff + 3'd1;
         end
      end
   end

   // Keyword matcher; a word starts fresh right after the backslash.
   always_comb begin
      fl_len     = (mode_ff == MODE_ESC) ? 4'd0 : word_len_ff;
      fl_match   = (mode_ff == MODE_ESC) ? 3'b111 : word_match_ff;
      tab_hit    = fl_match[0] && (fl_len < TAB_LEN) && (tab_char(fl_len) == in_byte);
      font_hit   = fl_match[1] && (fl_len < FONT_LEN) && (font_char(fl_len) == in_byte);
      color_hit  = fl_match[2] && (fl_len < COLOR_LEN) && (color_char(fl_len) == in_byte);
      tab_done   = tab_hit && (fl_len == TAB_LEN - 4'd1);
      font_done  = font_hit && (fl_len == FONT_LEN - 4'd1);
      color_done = color_hit && (fl_len == COLOR_LEN - 4'd1);
      fl_match_next = {color_hit && !color_done, font_hit && !font_done, tab_hit && !tab_done};
      fl_len_next   = (fl_len < WORD_SAT) ? fl_len + 4'd1 : fl_len;
   end

   // A byte that ends a control sequence is handled again as text unless it is blank.
   always_comb begin
      reproc = 1'b0;
      unique case (mode_ff)
         MODE_ESC: begin
            if (!(in_byte == CH_STAR || in_byte == CH_QUOTE || in_byte == CH_TILDE ||
                  in_byte == CH_LBRACE || in_byte == CH_RBRACE ||
                  in_byte == CH_BACKSLASH || in_byte == CH_NEWLINE ||
                  in_byte == CH_MINUS || in_byte == CH_UNDER || in_byte == CH_COLON ||
                  is_alpha(in_byte) || is_digit(in_byte))) begin
               reproc = !is_space(in_byte);
            end
         end
         MODE_ALPHA: begin
            if (!is_alpha(in_byte) && !(in_byte == CH_MINUS || is_digit(in_byte))) begin
               reproc = !is_space(in_byte);
            end
         end
         MODE_DIGITS: reproc = !is_digit(in_byte) && !is_space(in_byte);
         MODE_HEX: begin
            if (!(is_xdigit(in_byte) && word_len_ff < HEX_DIGITS)) begin
               reproc = !is_space(in_byte);
            end
         end
         MODE_AFTER: reproc = !is_space(in_byte);
         default:    reproc = 1'b0;
      endcase
   end

   assign text_emit = in_byte != CH_BACKSLASH && in_byte != CH_LBRACE &&
                      in_byte != CH_RBRACE && in_byte != CH_NEWLINE;

   // Next parse state.
   always_comb begin
      parse_mode  = mode_ff;
      parse_len   = word_len_ff;
      parse_match = word_match_ff;
      unique case (mode_ff)
         MODE_ESC: begin
            priority if (in_byte == CH_STAR) begin
               parse_mode = MODE_SKIP;
            end else if (in_byte == CH_QUOTE) begin
               parse_len  = 4'd0;
               parse_mode = MODE_HEX;
            end else if (in_byte == CH_TILDE || in_byte == CH_LBRACE ||
                         in_byte == CH_RBRACE || in_byte == CH_BACKSLASH ||
                         in_byte == CH_NEWLINE || in_byte == CH_MINUS ||
                         in_byte == CH_UNDER || in_byte == CH_COLON) begin
               parse_mode = MODE_AFTER;
            end else if (is_alpha(in_byte)) begin
               parse_len   = fl_len_next;
               parse_match = fl_match_next;
               parse_mode  = (font_done || color_done) ? MODE_SKIP : MODE_ALPHA;
            end else if (is_digit(in_byte)) begin
               parse_mode = MODE_DIGITS;
            end else begin
               parse_mode = MODE_TEXT;
            end
         end
         MODE_ALPHA: begin
            priority if (is_alpha(in_byte)) begin
               parse_len   = fl_len_next;
               parse_match = fl_match_next;
               if (font_done || color_done) begin
                  parse_mode = MODE_SKIP;
               end
            end else if (in_byte == CH_MINUS || is_digit(in_byte)) begin
               parse_mode = MODE_DIGITS;
            end else begin
               parse_mode = MODE_TEXT;
            end
         end
         MODE_DIGITS: begin
            if (!is_digit(in_byte)) begin
               parse_mode = MODE_TEXT;
            end
         end
         MODE_HEX: begin
            if (is_xdigit(in_byte) && word_len_ff < HEX_DIGITS) begin
               parse_len = word_len_ff + 4'd1;
            end else begin
               parse_mode = MODE_TEXT;
            end
         end
         MODE_AFTER: parse_mode = MODE_TEXT;
         MODE_SKIP: begin
            if (in_byte == CH_RBRACE) begin
               parse_mode = MODE_AFTER;
            end
         end
         default: parse_mode = (in_byte == CH_BACKSLASH) ? MODE_ESC : MODE_TEXT;
      endcase
      if (reproc) begin
         parse_mode = (in_byte == CH_BACKSLASH) ? MODE_ESC : MODE_TEXT;
      end
   end

   // Emitted byte for this step.
   always_comb begin
      emit      = 1'b0;
      emit_byte = 8'h00;
      unique case (mode_ff)
         MODE_ESC: begin
            priority if (in_byte == CH_QUOTE) begin
               emit      = 1'b1;
               emit_byte = CH_QUESTION;
            end else if (in_byte == CH_TILDE) begin
               emit      = 1'b1;
               emit_byte = CH_SPACE;
            end else if (in_byte == CH_LBRACE || in_byte == CH_RBRACE ||
                         in_byte == CH_BACKSLASH || in_byte == CH_NEWLINE) begin
               emit      = 1'b1;
               emit_byte = in_byte;
            end else if (is_alpha(in_byte) && tab_done) begin
               emit      = 1'b1;
               emit_byte = CH_TAB;
            end else begin
               emit = 1'b0;
            end
         end
         MODE_ALPHA: begin
            if (is_alpha(in_byte) && tab_done) begin
               emit      = 1'b1;
               emit_byte = CH_TAB;
            end
         end
         MODE_DIGITS, MODE_HEX, MODE_AFTER, MODE_SKIP: emit = 1'b0;
         default: begin
            emit      = text_emit;
            emit_byte = in_byte;
         end
      endcase
      if (reproc) begin
         emit      = text_emit;
         emit_byte = in_byte;
      end
      if (header_bad_in) begin
         emit      = 1'b0;
         emit_byte = 8'h00;
      end
   end

   // Result of this step.
   always_comb begin
      result.out_valid    = emit;
      result.out_byte     = emit ? emit_byte : 8'h00;
      result.doc_end      = last_byte;
      result.header_error = header_bad_in || (last_byte && header_pos_in < HEADER_LEN);
   end

   // State update; the end of a document returns everything to reset.
   always_comb begin
      mode_in       = mode_ff;
      word_len_in   = word_len_ff;
      word_match_in = word_match_ff;
      if (!header_bad_in) begin
         mode_in       = parse_mode;
         word_len_in   = parse_len;
         word_match_in = parse_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_TEXT;
         header_pos_ff <= 3'd0;
         header_bad_ff <= 1'b0;
         word_len_ff   <= 4'd0;
         word_match_ff <= 3'd0;
      end else if (step) begin
         if (last_byte) begin
            mode_ff       <= MODE_TEXT;
            header_pos_ff <= 3'd0;
            header_bad_ff <= 1'b0;
            word_len_ff   <= 4'd0;
            word_match_ff <= 3'd0;
         end else begin
            mode_ff       <= mode_in;
            header_pos_ff <= header_pos_in;
            header_bad_ff <= header_bad_in;
            word_len_ff   <= word_len_in;
            word_match_ff <= word_match_in;
         end
      end
   end

endmodule

>>> src/rtf_to_plain_text_filter.sv
// ----------------------------------------------------------------------------
// RTF to plain text filter
// Streams an RTF document byte by byte and returns one result per byte.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall) carries one document byte per
// transfer, with req_last_byte marking the final byte of a document. The
// response channel (rsp_valid, rsp_stall) returns exactly one result for
// every request transfer, in order: rsp_out_valid tells whether a plain text
// byte is present in rsp_out_byte, rsp_doc_end answers the final byte, and
// rsp_header_error flags a document that does not open with "{\rtf".
// A byte is captured in an input register, parsed from there and the
// result is held in an output register, where it is offered until it is
// taken. The parser state is a single mode update per byte, so one byte per
// cycle is sustained while the receiver does not stall.
// Reset clears both pipeline registers and the parser state. When the
// receiver stalls, the held result stays put, the input register takes one
// more byte if it is empty, and req_stall is raised while it holds a byte
// until the response is taken.
// ----------------------------------------------------------------------------
module rtf_to_plain_text_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_doc_end,
   output logic       rsp_header_error
);
   import rtfpt_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             out_valid_ff;
   rtfpt_result_type out_result_ff;
   rtfpt_result_type parse_result;
   logic             out_free;
   logic             advance;

   // Pipeline flow control.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_byte;
      end
   end

   rtfpt_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (parse_result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= parse_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_valid    = out_result_ff.out_valid;
   assign rsp_out_byte     = out_result_ff.out_byte;
   assign rsp_doc_end      = out_result_ff.doc_end;
   assign rsp_header_error = out_result_ff.header_error;

endmodule

>>> dv/rtfpt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTF to plain text filter checker
// Watches both channels of the filter, predicts the result of every accepted
// document byte, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rtfpt_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_out_valid,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_doc_end,
   input  logic       rsp_header_error,
   output int         mismatch_cnt,
   output int         pending_cnt
);
   import rtfpt_pkg::*;

   // Keywords, right aligned, and the slot each one holds in the match mask.
   localparam logic [39:0] RTF_HEADER = "{\\rtf";
   localparam logic [63:0] KW_TAB     = "tab";
   localparam logic [63:0] KW_FONT    = "fonttbl";
   localparam logic [63:0] KW_COLOR   = "colortbl";
   localparam int KW_SLOT_TAB   = 0;
   localparam int KW_SLOT_FONT  = 1;
   localparam int KW_SLOT_COLOR = 2;
   localparam int REPORT_LINES  = 40;

   // Shadow copy of the parser state.
   rtfpt_mode_type pmode;
   logic [2:0]     hdr_pos;
   logic           hdr_bad;
   logic [3:0]     kw_len;
   logic [2:0]     kw_alive;
   logic           emit_v;
   logic [7:0]     emit_b;

   // Results predicted but not yet seen on the response channel.
   rtfpt_result_type text_q[$];

   function automatic logic letter_p(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic numeral_p(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic hex_p(logic [7:0] c);
      return numeral_p(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic blank_p(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= 8'h0D);
   endfunction

   function automatic void clear_parser();
      pmode    = MODE_TEXT;
      hdr_pos  = '0;
      hdr_bad  = 1'b0;
      kw_len   = '0;
      kw_alive = '0;
   endfunction

   function automatic void emit(logic [7:0] c);
      emit_v = 1'b1;
      emit_b = c;
   endfunction

   // Advances one keyword candidate by a letter; true when the word completes.
   function automatic logic keyword_letter(int slot, logic [63:0] kw, int len,
                                           logic [7:0] c);
      int idx;
      idx = kw_len;
      if (!kw_alive[slot])
         return 1'b0;
      if (idx < len) begin
         if (kw[8*(len-1-idx) +: 8] == c) begin
            if (idx + 1 == len) begin
               kw_alive[slot] = 1'b0;
               return 1'b1;
            end
            return 1'b0;
         end
      end
      kw_alive[slot] = 1'b0;
      return 1'b0;
   endfunction

   function automatic void take_letter(logic [7:0] c);
      logic hit_tab;
      logic hit_font;
      logic hit_color;
      hit_tab   = keyword_letter(KW_SLOT_TAB, KW_TAB, TAB_LEN, c);
      hit_font  = keyword_letter(KW_SLOT_FONT, KW_FONT, FONT_LEN, c);
      hit_color = keyword_letter(KW_SLOT_COLOR, KW_COLOR, COLOR_LEN, c);
      if (kw_len < WORD_SAT)
         kw_len = kw_len + 4'd1;
      if (hit_tab)
         emit(CH_TAB);
      if (hit_font || hit_color)
         pmode = MODE_SKIP;
   endfunction

   // Predicts the result of one document byte and updates the shadow state.
   function automatic rtfpt_result_type filter_byte(logic [7:0] c, logic last);
      rtfpt_result_type res;
      logic redo;
      emit_v = 1'b0;
      emit_b = '0;

      // Header check runs on the first five bytes of every document.
      if (!hdr_bad && hdr_pos < HEADER_LEN) begin
         if (c != RTF_HEADER[8*(4-hdr_pos) +: 8])
            hdr_bad = 1'b1;
         else
            hdr_pos = hdr_pos + 3'd1;
      end

      // A byte ending a control sequence is handled again as text unless blank.
      if (!hdr_bad) begin
         redo = 1'b1;
         while (redo) begin
            redo = 1'b0;
            case (pmode)
               MODE_ESC: begin
                  if (c == CH_STAR) begin
                     pmode = MODE_SKIP;
                  end else if (c == CH_QUOTE) begin
                     emit(CH_QUESTION);
                     kw_len = '0;
                     pmode  = MODE_HEX;
                  end else if (c == CH_TILDE) begin
                     emit(CH_SPACE);
                     pmode = MODE_AFTER;
                  end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_BACKSLASH ||
                               c == CH_NEWLINE) begin
                     emit(c);
                     pmode = MODE_AFTER;
                  end else if (c == CH_MINUS || c == CH_UNDER || c == CH_COLON) begin
                     pmode = MODE_AFTER;
                  end else if (letter_p(c)) begin
                     kw_len   = '0;
                     kw_alive = 3'b111;
                     pmode    = MODE_ALPHA;
                     take_letter(c);
                  end else if (numeral_p(c)) begin
                     pmode = MODE_DIGITS;
                  end else begin
                     pmode = MODE_TEXT;
                     redo  = !blank_p(c);
                  end
               end
               MODE_ALPHA: begin
                  if (letter_p(c)) begin
                     take_letter(c);
                  end else if (c == CH_MINUS || numeral_p(c)) begin
                     pmode = MODE_DIGITS;
                  end else begin
                     pmode = MODE_TEXT;
                     redo  = !blank_p(c);
                  end
               end
               MODE_DIGITS: begin
                  if (!numeral_p(c)) begin
                     pmode = MODE_TEXT;
                     redo  = !blank_p(c);
                  end
               end
               MODE_HEX: begin
                  if (hex_p(c) && kw_len < HEX_DIGITS) begin
                     kw_len = kw_len + 4'd1;
                  end else begin
                     pmode = MODE_TEXT;
                     redo  = !blank_p(c);
                  end
               end
               MODE_AFTER: begin
                  pmode = MODE_TEXT;
                  redo  = !blank_p(c);
               end
               MODE_SKIP: begin
                  if (c == CH_RBRACE)
                     pmode = MODE_AFTER;
               end
               default: begin
                  pmode = MODE_TEXT;
                  if (c == CH_BACKSLASH)
                     pmode = MODE_ESC;
                  else if (c != CH_LBRACE && c != CH_RBRACE && c != CH_NEWLINE)
                     emit(c);
               end
            endcase
         end
      end

      res.out_valid    = emit_v;
      res.out_byte     = emit_v ? emit_b : 8'h00;
      res.doc_end      = last;
      res.header_error = hdr_bad || (last && hdr_pos < HEADER_LEN);

      // Every document starts from a clean parser.
      if (last)
         clear_parser();
      return res;
   endfunction

   // Counts one mismatch; only the first few are printed.
   task automatic report_mismatch(string msg);
      if (mismatch_cnt < REPORT_LINES)
         $display("%0t ns  mismatch: %s", $realtime, msg);
      mismatch_cnt++;
   endtask

   initial begin
      mismatch_cnt = 0;
      pending_cnt  = 0;
      emit_v       = 1'b0;
      emit_b       = '0;
      clear_parser();
   end

   // Compare result transfers first, then record the prediction for a new byte.
   always @(posedge clock) begin : watch_proc
      rtfpt_result_type want;
      rtfpt_result_type got;
      if (reset) begin
         clear_parser();
         text_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_valid, rsp_out_byte, rsp_doc_end, rsp_header_error};
            if (text_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: valid=%b byte=%h",
                                         got.out_valid, got.out_byte));
            end else begin
               want = text_q.pop_front();
               if (got.out_valid !== want.out_valid || got.doc_end !== want.doc_end ||
                   got.header_error !== want.header_error ||
                   got.out_byte !== want.out_byte)
                  report_mismatch($sformatf(
                     "want valid=%b byte=%h end=%b err=%b, got valid=%b byte=%h end=%b err=%b",
                     want.out_valid, want.out_byte, want.doc_end, want.header_error,
                     got.out_valid, got.out_byte, got.doc_end, got.header_error));
            end
         end
         if (req_valid && !req_stall)
            text_q.push_back(filter_byte(req_in_byte, req_last_byte));
      end
      pending_cnt = text_q.size();
   end

endmodule

>>> dv/tb_rtf_to_plain_text_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTF to plain text filter testbench
// Feeds hand-written and randomly built RTF documents through the filter with
// random gaps and receiver stalls, and leaves prediction to the checker.
// ----------------------------------------------------------------------------
module tb_rtf_to_plain_text_filter;
   import rtfpt_pkg::*;

   localparam int RAND_ITEMS  = 1200;
   localparam int CALM_ITEMS  = 150;
   localparam int LONG_HOLD   = 40;
   localparam int DRAIN_WAIT  = 8;
   localparam int CYCLE_LIMIT = 100000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_out_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_doc_end;
   logic       rsp_header_error;
   int         mismatch_cnt;
   int         pending_cnt;

   logic [7:0] doc_q[$];
   int         sent_cnt;
   int         cycle_cnt;
   int         holds_asked;
   bit         idle_on;

   rtf_to_plain_text_filter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_doc_end      (rsp_doc_end),
      .rsp_header_error (rsp_header_error)
   );

   rtfpt_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_doc_end      (rsp_doc_end),
      .rsp_header_error (rsp_header_error),
      .mismatch_cnt     (mismatch_cnt),
      .pending_cnt      (pending_cnt)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop for a hung pipeline.
   initial cycle_cnt = 0;
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: short random stalls, plus a long hold whenever one is asked for.
   initial begin
      int hold_left;
      int burst_left;
      int holds_done;
      rsp_stall  = 1'b0;
      hold_left  = 0;
      burst_left = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++)
         doc_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 4) == 0)
         return 8'("A" + $urandom_range(0, 25));
      return 8'("a" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_blank();
      if ($urandom_range(0, 2) == 0)
         return CH_SPACE;
      return 8'(CH_TAB + $urandom_range(0, 4));
   endfunction

   // Appends one random piece of RTF to the document under construction.
   task automatic add_token();
      int         n;
      string      w;
      logic [7:0] b;
      case ($urandom_range(0, 10))
         0: begin
            doc_q.push_back(8'($urandom_range(0, 255)));
         end
         1, 2: begin
            repeat ($urandom_range(1, 6))
               doc_q.push_back($urandom_range(0, 4) == 0 ? CH_SPACE : rand_letter());
         end
         3: begin
            // Control symbol, with up to three characters, mostly hex digits, after a quote.
            doc_q.push_back(CH_BACKSLASH);
            b = pick("{}\\\n~-_:*'");
            doc_q.push_back(b);
            if (b == CH_QUOTE)
               repeat ($urandom_range(0, 3))
                  doc_q.push_back(pick("0123456789abcdefABCDEFxg "));
         end
         4: begin
            // Control word: keyword prefix and/or letters, then maybe digits, maybe a blank.
            doc_q.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 4))
               0:       w = "tab";
               1:       w = "fonttbl";
               2:       w = "colortbl";
               3:       w = "par";
               default: w = "";
            endcase
            if (w.len() > 0)
               w = w.substr(0, $urandom_range(0, w.len() - 1));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 3);
            if (w.len() == 0 && n == 0)
               n = 1;
            add_text(w);
            repeat (n)
               doc_q.push_back(rand_letter());
            if ($urandom_range(0, 2) == 0) begin
               if ($urandom_range(0, 1) == 0)
                  doc_q.push_back(CH_MINUS);
               repeat ($urandom_range(1, 3))
                  doc_q.push_back(8'("0" + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 1) == 0)
               doc_q.push_back(rand_blank());
         end
         5: begin
            // Group that the filter skips up to its closing brace.
            doc_q.push_back(CH_LBRACE);
            doc_q.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 2))
               0:       add_text("*\\x");
               1:       add_text("fonttbl");
               default: add_text("colortbl");
            endcase
            repeat ($urandom_range(0, 6)) begin
               b = 8'($urandom_range(0, 255));
               if (b != CH_RBRACE)
                  doc_q.push_back(b);
            end
            doc_q.push_back(CH_RBRACE);
            if ($urandom_range(0, 1) == 0)
               doc_q.push_back(rand_blank());
         end
         6: begin
            doc_q.push_back(CH_BACKSLASH);
            doc_q.push_back(8'($urandom_range(0, 255)));
         end
         7: begin
            doc_q.push_back(rand_blank());
         end
         8: begin
            doc_q.push_back(CH_BACKSLASH);
            doc_q.push_back(CH_QUOTE);
            doc_q.push_back(pick("0123456789abcdefABCDEF"));
            doc_q.push_back(pick("0123456789abcdefABCDEF"));
         end
         default: begin
            doc_q.push_back(pick("{}\n"));
         end
      endcase
   endtask

   // Mostly well-formed documents; some short, some with a broken header and
   // some cut off at a random byte.
   task automatic make_doc();
      int    kind;
      int    cut;
      string hdr;
      hdr = "{\\rtf";
      doc_q.delete();
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         add_text(hdr.substr(0, $urandom_range(0, 3)));
      end else if (kind == 1) begin
         cut = $urandom_range(0, 4);
         if (cut > 0)
            add_text(hdr.substr(0, cut - 1));
         doc_q.push_back(8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 4))
            add_token();
      end else begin
         add_text(hdr);
         repeat ($urandom_range(1, 14))
            add_token();
         if ($urandom_range(0, 3) != 0)
            doc_q.push_back(CH_RBRACE);
         if (kind == 2 && doc_q.size() > 6) begin
            cut   = $urandom_range(6, doc_q.size());
            doc_q = doc_q[0:cut-1];
         end
      end
   endtask

   // One byte transfer, after an optional gap on the request side.
   task automatic send_byte(logic [7:0] b, logic last);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3))
            @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      do
         @(posedge clock);
      while (req_stall);
      sent_cnt++;
   endtask

   task automatic send_doc();
      for (int i = 0; i < doc_q.size(); i++)
         send_byte(doc_q[i], i == doc_q.size() - 1);
   endtask

   initial begin
      int mid_hold;
      req_valid     = 1'b0;
      req_in_byte   = '0;
      req_last_byte = 1'b0;
      idle_on       = 1'b0;
      holds_asked   = 0;
      sent_cnt      = 0;
      mid_hold      = 0;
      reset         = 1'b1;
      repeat (5)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed documents: short header, broken header, every escape,
      // skipped groups, a long word, and documents cut off mid-escape and
      // inside a skipped group.
      doc_q.delete();
      add_text("{\\r");
      send_doc();
      doc_q.delete();
      add_text("{\\rx}");
      send_doc();
      doc_q.delete();
      add_text("{\\rtf\\{\\}\\\\\\\n\\~\\'4fg\\-\\_\\:\\tabx\\b-2 \\q7z");
      doc_q.push_back(8'h00);
      doc_q.push_back(8'hFF);
      add_text("\\!\\ }");
      send_doc();
      doc_q.delete();
      add_text("{\\rtf{\\*a}{\\fonttbl}{\\colortbl}\\abcdefghijk \\");
      send_doc();
      doc_q.delete();
      add_text("{\\rtf{\\*x");
      send_doc();

      // Random documents, opening with a long receiver hold and with another one halfway through.
      sent_cnt = 0;
      holds_asked++;
      while (sent_cnt < RAND_ITEMS) begin
         if (!mid_hold && sent_cnt > RAND_ITEMS / 2) begin
            mid_hold = 1;
            holds_asked++;
         end
         idle_on = (sent_cnt < RAND_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
         make_doc();
         send_doc();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait (pending_cnt == 0);
      repeat (DRAIN_WAIT)
         @(posedge clock);
      if (mismatch_cnt == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> rtf_to_plain_text_filter.f
src/rtfpt_pkg.sv
src/rtfpt_parser.sv
src/rtf_to_plain_text_filter.sv
dv/rtfpt_checker.sv
dv/tb_rtf_to_plain_text_filter.sv
